@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the swap planner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prsp assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define PRSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prsp assertion failed: next-cycle implication");

`endif

@@ rtl/prsp_pkg.sv @@
`default_nettype none

package prsp_pkg;

    // Number of rows the bitmap covers.
    localparam int ROWS = 64;

    localparam int ROW_W = 6;
    localparam int CNT_W = 7;
    localparam int CFG_W = 7;
    localparam int SUM_W = CFG_W + 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Input command codes.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef logic [ROWS-1:0] row_map_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       mark;        // load beat accepted
        logic       capture;     // finish beat accepted
        logic       chk_pop;     // drop lowest bit of both check copies
        logic       put_status;  // write a status-only result
        logic       put_pair;    // write a swap pair and pop it
        logic [1:0] status;
    } prsp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty_range;
        logic range_err;
        logic chk_e_zero;
        logic chk_l_zero;
        logic pairs_none;
        logic pair_final;
        logic slot_free;
    } prsp_sts_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [ROW_W-1:0] lowest_index(input row_map_t x);
        row_map_t         onehot;
        logic [ROW_W-1:0] idx;
        onehot = x & (~x + row_map_t'(1));
        idx    = '0;
        for (int i = 0; i < ROWS; i++) begin
            if (onehot[i]) begin
                idx = idx | ROW_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/prsp_ctrl.sv @@
`default_nettype none

module prsp_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire                  s_cmd,
    input  wire prsp_pkg::prsp_sts_t sts,
    output prsp_pkg::prsp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_SINGLE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.status     = status_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_cmd == prsp_pkg::CMD_LOAD) begin
                        cmd.mark = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        if (sts.empty_range) begin
                            status_next = prsp_pkg::ST_EMPTY;
                            state_next  = S_SINGLE;
                        end else if (sts.range_err) begin
                            status_next = prsp_pkg::ST_RANGE;
                            state_next  = S_SINGLE;
                        end else begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (sts.chk_e_zero && sts.chk_l_zero) begin
                    if (sts.pairs_none) begin
                        status_next = prsp_pkg::ST_OK;
                        state_next  = S_SINGLE;
                    end else begin
                        status_next = prsp_pkg::ST_OK;
                        state_next  = S_EMIT;
                    end
                end else if (sts.chk_e_zero || sts.chk_l_zero) begin
                    status_next = prsp_pkg::ST_MISMATCH;
                    state_next  = S_SINGLE;
                end else begin
                    cmd.chk_pop = 1'b1;
                end
            end
            S_SINGLE: begin
                if (sts.slot_free) begin
                    cmd.put_status = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT: begin
                if (sts.slot_free) begin
                    cmd.put_pair = 1'b1;
                    if (sts.pair_final) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= prsp_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/prsp_dp.sv @@
`default_nettype none

module prsp_dp (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire prsp_pkg::prsp_cmd_t          cmd,
    output prsp_pkg::prsp_sts_t               sts,
    input  wire [prsp_pkg::ROW_W-1:0]         pick_row,
    input  wire [prsp_pkg::CFG_W-1:0]         first_open_row,
    input  wire [prsp_pkg::CFG_W-1:0]         row_total,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [prsp_pkg::ROW_W-1:0]        early_row,
    output logic [prsp_pkg::ROW_W-1:0]        late_row,
    output logic                              pair_valid,
    output logic [1:0]                        status,
    output logic                              last
);

    prsp_pkg::row_map_t pivot_map_reg, pivot_map_next;
    logic [prsp_pkg::CNT_W-1:0] pivot_count_reg, pivot_count_next;
    logic range_error_reg, range_error_next;

    // Early and late candidate masks, plus copies consumed by the check pass.
    prsp_pkg::row_map_t e_reg, e_next, l_reg, l_next;
    prsp_pkg::row_map_t ce_reg, ce_next, cl_reg, cl_next;

    logic m_tvalid_reg, m_tvalid_next;
    logic [prsp_pkg::ROW_W-1:0] early_reg, early_next, late_reg, late_next;
    logic pv_reg, pv_next, last_reg, last_next;
    logic [1:0] status_reg, status_next;

    logic [prsp_pkg::CFG_W-1:0] rows_eff;
    logic [prsp_pkg::SUM_W-1:0] win_start, win_end, late_start, rows_ext;
    logic row_bad;
    prsp_pkg::row_map_t e_mask, l_mask;

    assign rows_eff = (row_total > prsp_pkg::CFG_W'(prsp_pkg::ROWS)) ?
                      prsp_pkg::CFG_W'(prsp_pkg::ROWS) : row_total;
    assign rows_ext   = {1'b0, rows_eff};
    assign win_start  = {1'b0, first_open_row};
    assign late_start = win_start + {1'b0, pivot_count_reg};
    assign win_end    = (late_start > rows_ext) ? rows_ext : late_start;

    assign row_bad = ({1'b0, pick_row} < first_open_row) ||
                     ({1'b0, pick_row} >= rows_eff);

    // Early rows are open window rows without a pivot; late rows are pivots past it.
    always_comb begin
        for (int i = 0; i < prsp_pkg::ROWS; i++) begin
            e_mask[i] = !pivot_map_reg[i] &&
                        (prsp_pkg::SUM_W'(i) >= win_start) && (prsp_pkg::SUM_W'(i) < win_end);
            l_mask[i] = pivot_map_reg[i] &&
                        (prsp_pkg::SUM_W'(i) >= late_start) && (prsp_pkg::SUM_W'(i) < rows_ext);
        end
    end

    always_comb begin
        pivot_map_next   = pivot_map_reg;
        pivot_count_next = pivot_count_reg;
        range_error_next = range_error_reg;
        e_next  = e_reg;
        l_next  = l_reg;
        ce_next = ce_reg;
        cl_next = cl_reg;
        if (cmd.mark) begin
            if (row_bad) begin
                range_error_next = 1'b1;
            end else begin
                for (int i = 0; i < prsp_pkg::ROWS; i++) begin
                    if (prsp_pkg::ROW_W'(i) == pick_row) begin
                        pivot_map_next[i] = 1'b1;
                    end
                end
            end
            if (pivot_count_reg != prsp_pkg::COUNT_MAX) begin
                pivot_count_next = pivot_count_reg + prsp_pkg::CNT_W'(1);
            end
        end
        if (cmd.capture) begin
            e_next  = e_mask;
            l_next  = l_mask;
            ce_next = e_mask;
            cl_next = l_mask;
            pivot_map_next   = '0;
            pivot_count_next = '0;
            range_error_next = 1'b0;
        end
        if (cmd.chk_pop) begin
            ce_next = ce_reg & (ce_reg - prsp_pkg::row_map_t'(1));
            cl_next = cl_reg & (cl_reg - prsp_pkg::row_map_t'(1));
        end
        if (cmd.put_pair) begin
            e_next = e_reg & (e_reg - prsp_pkg::row_map_t'(1));
            l_next = l_reg & (l_reg - prsp_pkg::row_map_t'(1));
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        early_next    = early_reg;
        late_next     = late_reg;
        pv_next       = pv_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        if (cmd.put_status) begin
            m_tvalid_next = 1'b1;
            early_next    = '0;
            late_next     = '0;
            pv_next       = 1'b0;
            status_next   = cmd.status;
            last_next     = 1'b1;
        end else if (cmd.put_pair) begin
            m_tvalid_next = 1'b1;
            early_next    = prsp_pkg::lowest_index(e_reg);
            late_next     = prsp_pkg::lowest_index(l_reg);
            pv_next       = 1'b1;
            status_next   = prsp_pkg::ST_OK;
            last_next     = sts.pair_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivot_map_reg   <= '0;
            pivot_count_reg <= '0;
            range_error_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            pivot_map_reg   <= pivot_map_next;
            pivot_count_reg <= pivot_count_next;
            range_error_reg <= range_error_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg      <= e_next;
        l_reg      <= l_next;
        ce_reg     <= ce_next;
        cl_reg     <= cl_next;
        early_reg  <= early_next;
        late_reg   <= late_next;
        pv_reg     <= pv_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign sts.empty_range = (first_open_row >= rows_eff);
    assign sts.range_err   = range_error_reg;
    assign sts.chk_e_zero  = (ce_reg == '0);
    assign sts.chk_l_zero  = (cl_reg == '0);
    assign sts.pairs_none  = (e_reg == '0);
    assign sts.pair_final  = ((e_reg & (e_reg - prsp_pkg::row_map_t'(1))) == '0);
    assign sts.slot_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid   = m_tvalid_reg;
    assign early_row  = early_reg;
    assign late_row   = late_reg;
    assign pair_valid = pv_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

@@ rtl/pivot_row_swap_planner.sv @@
// Channel   | Dir | Beat contents
// s_ (in)   | in  | tdata[5:0] pick_row; tuser cmd (0 load, 1 finish)
// m_ (out)  | out | tdata[5:0] early_row, [11:6] late_row; tuser[0] pair_valid,
//           |     | tuser[2:1] status; tlast marks the final beat of a finish
// APB cfg   | in  | 0x0 first_open_row, 0x4 row_total
//
// A load beat produces no output beat. A finish beat builds the candidate masks in the
// cycle it is taken. An empty range or a range error then writes one status beat;
// otherwise a check pass compares the mask counts, then the output beats follow (each
// swap pair, or one status beat). Reset is synchronous and active low; it clears the
// bitmap, count, error flag, the controller and the output valid. s_tready stays low
// until the last beat of a finish is written, so output stalls keep it low longer.
`default_nettype none

module pivot_row_swap_planner (
    input  wire         aclk,
    input  wire         aresetn,
    // Input stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [5:0] pick_row, [7:6] zero
    input  wire         s_tuser,   // [0] cmd
    // Result stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [5:0] early_row, [11:6] late_row, [15:12] zero
    output logic [2:0]  m_tuser,   // [0] pair_valid, [2:1] status
    output logic        m_tlast,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [prsp_pkg::CFG_W-1:0] first_open_row_reg, first_open_row_next;
    logic [prsp_pkg::CFG_W-1:0] row_total_reg, row_total_next;
    logic                       cfg_wr;

    prsp_pkg::prsp_cmd_t cmd;
    prsp_pkg::prsp_sts_t sts;

    logic [prsp_pkg::ROW_W-1:0] early_row, late_row;
    logic                       pair_valid, last;
    logic [1:0]                 status;

    // The register file answers every access without wait states. Address bit 2 picks the
    // register; the lower byte-offset bits are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        first_open_row_next = first_open_row_reg;
        row_total_next      = row_total_reg;
        if (cfg_wr) begin
            if (paddr[2] == 1'b0) begin
                first_open_row_next = pwdata[prsp_pkg::CFG_W-1:0];
            end else begin
                row_total_next = pwdata[prsp_pkg::CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_open_row_reg <= '0;
            row_total_reg      <= prsp_pkg::CFG_W'(prsp_pkg::ROWS);
        end else begin
            first_open_row_reg <= first_open_row_next;
            row_total_reg      <= row_total_next;
        end
    end

    assign prdata = paddr[2] ? {{(32 - prsp_pkg::CFG_W){1'b0}}, row_total_reg}
                             : {{(32 - prsp_pkg::CFG_W){1'b0}}, first_open_row_reg};

    // The controller sequences load, check and emit; the datapath holds the bitmap,
    // the candidate masks and the output register.
    prsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    prsp_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .pick_row       (s_tdata[prsp_pkg::ROW_W-1:0]),
        .first_open_row (first_open_row_reg),
        .row_total      (row_total_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .early_row      (early_row),
        .late_row       (late_row),
        .pair_valid     (pair_valid),
        .status         (status),
        .last           (last)
    );

    assign m_tdata = {4'b0000, late_row, early_row};
    assign m_tuser = {status, pair_valid};
    assign m_tlast = last;

endmodule

`default_nettype wire

@@ rtl/prsp_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module prsp_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire [2:0]  m_tuser,
    input wire        m_tlast
);

    // A stalled result beat keeps its payload.
    `PRSP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A beat without a swap pair carries zero rows and ends the finish.
    `PRSP_ASSERT_IMP(a_nopair_last, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == 16'd0))

    // An error status never comes with a swap pair.
    `PRSP_ASSERT_IMP(a_err_nopair, aclk, aresetn, m_tvalid && (m_tuser[2:1] != 2'd0), !m_tuser[0])

    // After a finish beat is taken the input side stalls until results are out.
    `PRSP_ASSERT_NXT(a_finish_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser, !s_tready)

endmodule

bind pivot_row_swap_planner prsp_checker u_prsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
